[rtl/scc_pkg.sv]
// Package for the sidechain compressor: widths, register codes and curve tables.
// No dependencies; used by rtl/sidechain_compressor.sv.
package scc_pkg;
    localparam int Channels = 2;
    localparam int ChW = (Channels > 1) ? $clog2(Channels) : 1;
    localparam int SampW = 24;
    localparam int CfgW = 24;
    localparam int IdxW = 3;

    localparam logic [IdxW-1:0] REG_THR = 3'd0;
    localparam logic [IdxW-1:0] REG_SLOPE = 3'd1;
    localparam logic [IdxW-1:0] REG_MIX = 3'd2;
    localparam logic [IdxW-1:0] REG_ATT = 3'd3;
    localparam logic [IdxW-1:0] REG_REL = 3'd4;

    function automatic logic [16:0] log2_lut(input logic [4:0] k);
        unique case (k)
            5'd0: log2_lut = 17'd0;      5'd1: log2_lut = 17'd5732;
            5'd2: log2_lut = 17'd11136;  5'd3: log2_lut = 17'd16248;
            5'd4: log2_lut = 17'd21098;  5'd5: log2_lut = 17'd25711;
            5'd6: log2_lut = 17'd30109;  5'd7: log2_lut = 17'd34312;
            5'd8: log2_lut = 17'd38336;  5'd9: log2_lut = 17'd42196;
            5'd10: log2_lut = 17'd45904; 5'd11: log2_lut = 17'd49472;
            5'd12: log2_lut = 17'd52911; 5'd13: log2_lut = 17'd56229;
            5'd14: log2_lut = 17'd59434; 5'd15: log2_lut = 17'd62534;
            default: log2_lut = 17'd65536;
        endcase
    endfunction

    function automatic logic [16:0] exp2_lut(input logic [4:0] k);
        unique case (k)
            5'd0: exp2_lut = 17'd65536;  5'd1: exp2_lut = 17'd62757;
            5'd2: exp2_lut = 17'd60097;  5'd3: exp2_lut = 17'd57549;
            5'd4: exp2_lut = 17'd55109;  5'd5: exp2_lut = 17'd52773;
            5'd6: exp2_lut = 17'd50535;  5'd7: exp2_lut = 17'd48393;
            5'd8: exp2_lut = 17'd46341;  5'd9: exp2_lut = 17'd44376;
            5'd10: exp2_lut = 17'd42495; 5'd11: exp2_lut = 17'd40693;
            5'd12: exp2_lut = 17'd38968; 5'd13: exp2_lut = 17'd37316;
            5'd14: exp2_lut = 17'd35734; 5'd15: exp2_lut = 17'd34219;
            default: exp2_lut = 17'd32768;
        endcase
    endfunction
endpackage

[rtl/sidechain_compressor.sv]
// Sidechain-keyed peak compressor with hard knee, one shared multiplier under a sequencer.
// Depends on rtl/scc_pkg.sv for widths, register codes and the log2/exp2 tables.
//
// Usage: the input channel carries a beat of channel number, main sample and
// sidechain sample (i_valid / o_stall); the output channel carries one compressed
// sample per input beat (o_valid / i_stall). A beat is accepted when valid is
// high and stall is low. The user must write registers through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_data) only while the block is idle; it is not enforced.
//
// Sequencing: a beat runs through the sequencer steps to the output register,
// and the next beat is accepted only once the result has left the output
// register, so the block does not take a new beat before the last is through.
// The steps share the single 33x33 signed multiplier, used once in each step
// that multiplies: two steps for the envelope, one for the log interpolation,
// one for the dB scale, one for the slope, one for the octave scale, one for
// the exp interpolation, then three for gain, dry share and wet share.
// When mix is zero the result is valid in the cycle after acceptance.
//
// Reset clears the envelopes of all channels, the sequencer, the output
// valid, and loads the register reset values. When the receiver stalls, the
// result holds in the output register; the sequencer finishes its current
// beat and then waits with o_stall high until the output register drains.
module sidechain_compressor
    import scc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [IdxW-1:0]         i_cfg_idx,
    input  logic [CfgW-1:0]         i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_channel,
    input  logic signed [SampW-1:0] i_main_sample,
    input  logic signed [SampW-1:0] i_side_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SampW-1:0] o_out_sample
);
    // Sequencer step codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ENV1 = 4'd1;  // c*env
    localparam logic [3:0] S_ENV2 = 4'd2;  // (2^24-c)*lvl, add, round
    localparam logic [3:0] S_LOGI = 4'd3;  // log2 interpolation
    localparam logic [3:0] S_DB = 4'd4;    // neg * 6313057
    localparam logic [3:0] S_SLP = 4'd5;   // excess * slope
    localparam logic [3:0] S_OCT = 4'd6;   // r * 44586162
    localparam logic [3:0] S_EXPI = 4'd7;  // exp2 interpolation
    localparam logic [3:0] S_WET = 4'd8;   // main * g
    localparam logic [3:0] S_DRY = 4'd9;   // main * (65536-m)
    localparam logic [3:0] S_MIXW = 4'd10; // wet * m, sum, round, saturate
    localparam logic [3:0] S_OUT = 4'd11;  // hand to output
    localparam logic [3:0] S_NORM = 4'd12; // leading one of the envelope

    localparam logic [23:0] FullMag = 24'd8388608;

    // Configuration registers.
    logic signed [10:0] r_thr;
    logic [15:0]        r_slope;
    logic [16:0]        r_mix;
    logic [23:0]        r_att;
    logic [23:0]        r_rel;

    logic [23:0]        r_env [Channels];
    logic [3:0]         r_state, n_state;
    logic [ChW-1:0]     r_ch;
    logic signed [23:0] r_main;
    logic [23:0]        r_lvl;
    logic [23:0]        r_cur;      // envelope under work
    logic [23:0]        r_coef;
    logic [63:0]        r_acc;      // product accumulator
    logic [21:0]        r_neg;      // -L in Q16, at most 23*65536
    logic signed [12:0] r_db;
    logic [16:0]        r_gain;
    logic signed [41:0] r_wet;
    logic               r_ovalid;
    logic signed [23:0] r_out;

    // Clamped registers.
    logic signed [10:0] thr_c;
    logic [15:0]        slope_c;
    logic [16:0]        mix_c;
    always_comb begin
        thr_c = r_thr;
        if (r_thr < -11'sd960) thr_c = -11'sd960;
        if (r_thr > 11'sd0) thr_c = 11'sd0;
        slope_c = (r_slope > 16'd62259) ? 16'd62259 : r_slope;
        mix_c = (r_mix > 17'd65536) ? 17'd65536 : r_mix;
    end

    // Shared multiplier: two 33-bit signed operands give one 66-bit signed
    // product; operands here stay within 32 bits.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Log2 normalize of r_cur.
    logic [4:0]  lz_p;
    logic [23:0] mant;
    always_comb begin
        lz_p = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (r_cur[i]) lz_p = 5'(i);
        end
        if (lz_p > 5'd23) lz_p = 5'd23;
        mant = r_cur << (5'd23 - lz_p);
    end
    logic [3:0]  log_idx;
    logic [18:0] log_rem;
    logic [16:0] log_t0, log_t1;
    assign log_idx = mant[22:19];
    assign log_rem = mant[18:0];
    assign log_t0 = log2_lut({1'b0, log_idx});
    assign log_t1 = log2_lut(5'({1'b0, log_idx}) + 5'd1);

    // Exp2 fields of e held in r_acc after S_OCT.
    logic [31:0] e_val;
    logic [15:0] e_int;
    logic [3:0]  exp_idx;
    logic [11:0] exp_rem;
    logic [16:0] exp_t0, exp_t1;
    assign e_val = r_acc[31:0];
    assign e_int = e_val[31:16];
    assign exp_idx = e_val[15:12];
    assign exp_rem = e_val[11:0];
    assign exp_t0 = exp2_lut({1'b0, exp_idx});
    assign exp_t1 = exp2_lut(5'({1'b0, exp_idx}) + 5'd1);

    logic accept;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign accept = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_out_sample = r_out;

    logic [23:0] side_abs;
    assign side_abs = i_side_sample[23] ? 24'(-i_side_sample) : i_side_sample;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_ENV1: begin
                mul_a = 33'(r_coef);
                mul_b = 33'(r_cur);
            end
            S_ENV2: begin
                mul_a = 33'(25'h1000000 - 25'(r_coef));
                mul_b = 33'(r_lvl);
            end
            S_LOGI: begin
                mul_a = 33'(log_t1 - log_t0);
                mul_b = 33'(log_rem);
            end
            S_DB: begin
                mul_a = 33'(r_neg);
                mul_b = 33'd6313057;
            end
            S_SLP: begin
                mul_a = 33'(13'(r_db - 13'(thr_c)));
                mul_b = 33'(slope_c);
            end
            S_OCT: begin
                mul_a = 33'(r_acc[15:0]);
                mul_b = 33'd44586162;
            end
            S_EXPI: begin
                mul_a = 33'(exp_t0 - exp_t1);
                mul_b = 33'(exp_rem);
            end
            S_WET: begin
                mul_a = 33'(r_main);
                mul_b = 33'(r_gain);
            end
            S_DRY: begin
                mul_a = 33'(r_main);
                mul_b = 33'(17'd65536 - mix_c);
            end
            S_MIXW: begin
                mul_a = 33'(r_wet);
                mul_b = 33'(mix_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic [64:0] env_sum;
    logic [23:0] env_new;
    logic [42:0] db_prod;
    logic [31:0] excess_r;
    logic [16:0] g_int;
    logic signed [65:0] mix_sum, mix_rnd;
    always_comb begin
        env_sum = 65'(r_acc) + 65'(mul_p[63:0]) + 65'd8388608;
        env_new = (env_sum[48:24] > 25'(FullMag)) ? FullMag : env_sum[47:24];
        db_prod = 43'((mul_p[53:0] + 54'd2147483648) >> 32);
        excess_r = 32'((mul_p[31:0] + 32'd32768) >> 16);
        g_int = exp_t0 - 17'(mul_p[28:12]);
        mix_sum = $signed(r_acc) + mul_p;
        mix_rnd = (mix_sum + 66'sd32768) >>> 16;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && mix_c != 17'd0) n_state = S_ENV1;
            S_ENV1:  n_state = S_ENV2;
            S_ENV2:  n_state = S_NORM;
            S_NORM:  n_state = (r_cur == 24'd0) ? S_WET : S_LOGI;
            S_LOGI:  n_state = S_DB;
            S_DB:    n_state = S_SLP;
            S_SLP:   n_state = (r_db > 13'(thr_c)) ? S_OCT : S_WET;
            S_OCT:   n_state = S_EXPI;
            S_EXPI:  n_state = S_WET;
            S_WET:   n_state = S_DRY;
            S_DRY:   n_state = S_MIXW;
            S_MIXW:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= -11'sd320;
            r_slope <= 16'd49152;
            r_mix <= 17'd65536;
            r_att <= 24'd16707456;
            r_rel <= 24'd16773721;
            for (int i = 0; i < Channels; i++) r_env[i] <= '0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THR:   r_thr <= i_cfg_data[10:0];
                    REG_SLOPE: r_slope <= i_cfg_data[15:0];
                    REG_MIX:   r_mix <= i_cfg_data[16:0];
                    REG_ATT:   r_att <= i_cfg_data[23:0];
                    REG_REL:   r_rel <= i_cfg_data[23:0];
                    default:   ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (accept && mix_c == 17'd0) r_ovalid <= 1'b1;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            if (r_state == S_ENV2) r_env[r_ch] <= env_new;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ch <= (32'(i_channel) >= Channels) ? ChW'(Channels - 1)
                                                        : ChW'(i_channel);
                    r_main <= i_main_sample;
                    r_lvl <= side_abs;
                    r_out <= i_main_sample;
                    r_gain <= 17'd65536;
                    begin
                        logic [ChW-1:0] ch;
                        ch = (32'(i_channel) >= Channels) ? ChW'(Channels - 1)
                                                         : ChW'(i_channel);
                        r_cur <= r_env[ch];
                        r_coef <= (side_abs > r_env[ch]) ? r_att : r_rel;
                    end
                end
            end
            S_ENV1: r_acc <= mul_p[63:0];
            S_ENV2: r_cur <= env_new;
            S_NORM: r_acc <= '0;
            S_LOGI: r_neg <= 22'(22'(5'd23 - lz_p) * 22'd65536)
                             - 22'(log_t0 + 17'(mul_p[35:19]));
            S_DB:   r_db <= -13'(db_prod[12:0]);
            S_SLP:  r_acc <= 64'(excess_r);
            S_OCT:  r_acc <= 64'((mul_p[63:0] + 64'd32768) >> 16);
            S_EXPI: r_gain <= (e_int >= 16'd17) ? 17'd0 : (g_int >> e_int[4:0]);
            S_WET:  r_wet <= 42'(($signed(mul_p) + 66'sd32768) >>> 16);
            S_DRY:  r_acc <= mul_p[63:0];
            S_MIXW: begin
                if (mix_rnd > 66'sd8388607) r_out <= 24'sd8388607;
                else if (mix_rnd < -66'sd8388608) r_out <= -24'sd8388608;
                else r_out <= mix_rnd[23:0];
            end
            default: ;
        endcase
    end

    // The sequencer only leaves idle through an accepted beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_ENV1) |-> accept)
        else $error("sequencer started without a beat");
    // A result is presented only after the final step or a bypass.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT || $past(accept)))
        else $error("output valid without a finished beat");
    // The envelope never exceeds full scale.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_cur <= FullMag))
        else $error("envelope above full scale");
    // No beat is accepted while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !accept)
        else $error("beat accepted over a pending result");
endmodule

[test/scc_checker.sv]
// Checker for the sidechain compressor: watches both channels, predicts each output beat.
// Depends on rtl/scc_pkg.sv for widths and register codes.
`timescale 1ns / 100ps

module scc_checker
    import scc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [IdxW-1:0]         i_cfg_idx,
    input  logic [CfgW-1:0]         i_cfg_data,
    input  logic                    i_valid,
    input  logic                    i_stall_in,
    input  logic                    i_channel,
    input  logic signed [SampW-1:0] i_main_sample,
    input  logic signed [SampW-1:0] i_side_sample,
    input  logic                    i_valid_out,
    input  logic                    i_stall_out,
    input  logic signed [SampW-1:0] i_out_sample,
    output int                      o_errors,
    output int                      o_pending
);
    localparam logic [16:0] LOG_TAB [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
        34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    localparam logic [16:0] EXP_TAB [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    logic signed [10:0] thr_q;
    logic [15:0] slope_q;
    logic [16:0] mix_q;
    logic [23:0] att_q, rel_q;
    logic [23:0] env_q [Channels];
    logic signed [23:0] expected_samples [$];

    assign o_pending = expected_samples.size();

    // Level of a nonzero envelope in 1/16 dB relative to full scale.
    function automatic longint env_to_db16(input logic [23:0] env);
        int p;
        logic [23:0] m;
        logic [22:0] frac;
        longint idx, rem, t, neg;
        p = 0;
        while (p < 23 && (env >> (p + 1)) != 0) p++;
        m = env << (23 - p);
        frac = m[22:0];
        idx = frac[22:19];
        rem = frac[18:0];
        t = LOG_TAB[idx] + (((LOG_TAB[idx + 1] - LOG_TAB[idx]) * rem) >>> 19);
        neg = longint'(23 - p) * 65536 - t;
        return -((neg * 6313057 + (64'sd1 << 31)) >>> 32);
    endfunction

    // Linear gain in Q16 for an attenuation in 1/16 dB.
    function automatic longint atten_to_gain(input longint r);
        longint e, n, f, idx, rem, g;
        e = (r * 44586162 + 32768) >>> 16;
        n = e >>> 16;
        f = e & 16'hFFFF;
        idx = f >>> 12;
        rem = f & 12'hFFF;
        g = EXP_TAB[idx] - (((EXP_TAB[idx] - EXP_TAB[idx + 1]) * rem) >>> 12);
        if (n >= 17) return 0;
        return g >>> n;
    endfunction

    // Floor division by 2^s after adding half, i.e. round half up.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [23:0] compress_beat(input logic ch,
        input logic signed [23:0] dry, input logic signed [23:0] side);
        longint mix, thr, slope, lvl, env, c, g, db, r, wet, res;
        int k;
        k = (int'(ch) >= Channels) ? Channels - 1 : int'(ch);
        mix = (mix_q > 65536) ? 65536 : mix_q;
        thr = thr_q;
        if (thr < -960) thr = -960;
        if (thr > 0) thr = 0;
        slope = (slope_q > 62259) ? 62259 : slope_q;
        if (mix == 0) return dry;
        lvl = (side < 0) ? -longint'(side) : longint'(side);
        env = env_q[k];
        c = (lvl > env) ? att_q : rel_q;
        env = (c * env + (64'sd16777216 - c) * lvl + 8388608) >>> 24;
        if (env > 8388608) env = 8388608;
        env_q[k] = env[23:0];
        g = 65536;
        if (env != 0) begin
            db = env_to_db16(env[23:0]);
            if (db > thr) begin
                r = ((db - thr) * slope + 32768) >>> 16;
                g = atten_to_gain(r);
            end
        end
        wet = round_half_up(longint'(dry) * g, 16);
        res = round_half_up(longint'(dry) * (65536 - mix) + wet * mix, 16);
        if (res > 8388607) res = 8388607;
        if (res < -8388608) res = -8388608;
        return res[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_q <= -11'sd320;
            slope_q <= 16'd49152;
            mix_q <= 17'd65536;
            att_q <= 24'd16707456;
            rel_q <= 24'd16773721;
            for (int i = 0; i < Channels; i++) env_q[i] = '0;
            expected_samples.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THR: thr_q <= i_cfg_data[10:0];
                    REG_SLOPE: slope_q <= i_cfg_data[15:0];
                    REG_MIX: mix_q <= i_cfg_data[16:0];
                    REG_ATT: att_q <= i_cfg_data[23:0];
                    REG_REL: rel_q <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                expected_samples.push_back(compress_beat(i_channel, i_main_sample,
                    i_side_sample));
            if (i_valid_out && !i_stall_out) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: output beat %0d with nothing expected", $time,
                        i_out_sample);
                    o_errors <= o_errors + 1;
                end else begin
                    if (i_out_sample !== expected_samples[0]) begin
                        $display("%0t: out_sample expected %0d actual %0d", $time,
                            expected_samples[0], i_out_sample);
                        o_errors <= o_errors + 1;
                    end
                    void'(expected_samples.pop_front());
                end
            end
        end
    end
endmodule

[test/testbench.sv]
// Top of the sidechain compressor testbench: clock, reset, stimulus, verdict.
// Depends on rtl/scc_pkg.sv, rtl/sidechain_compressor.sv and test/scc_checker.sv.
`timescale 1ns / 100ps

module testbench;
    import scc_pkg::*;

    localparam int WatchdogLimit = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0] i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic i_channel;
    logic signed [SampW-1:0] i_main_sample;
    logic signed [SampW-1:0] i_side_sample;
    logic o_valid;
    logic i_stall;
    logic signed [SampW-1:0] o_out_sample;

    int error_count;
    int pending_count;
    int idle_cycles;
    bit quiet_sink;        // no random stalls near the end of the run
    bit hold_sink;         // a long receiver hold-off requested by the stimulus

    sidechain_compressor uut (.*);

    scc_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_channel, .i_main_sample, .i_side_sample,
        .i_valid_out(o_valid), .i_stall_out(i_stall), .i_out_sample(o_out_sample),
        .o_errors(error_count), .o_pending(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls in random bursts. When asked, it holds off for a long
    // stretch so that the block fills and stalls its input.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                i_stall <= 1'b1;
                for (int i = 0; i < 120; i++) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_sink = 1'b0;
            end else if (!quiet_sink && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // The watchdog ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one beat and hold it until the block takes it. With gaps allowed,
    // a random idle burst may come first.
    task automatic send_beat(input logic ch, input logic [23:0] main_s,
        input logic [23:0] side_s, input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_channel <= ch;
        i_main_sample <= main_s;
        i_side_sample <= side_s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering beats and wait until every expected result has arrived,
    // then let the block settle before any register write.
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Samples biased toward the extremes and toward quiet levels, where the
    // envelope log and the threshold compare have their corner cases.
    function automatic logic [23:0] pick_sample;
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(0, 255) - 128);
            3: return 24'(($urandom & 24'hFFFFFF) >>> $urandom_range(0, 20));
            default: return 24'($urandom & 24'hFFFFFF);
        endcase
    endfunction

    // One random setting: threshold, slope and mix include values beyond the
    // clamp limits, since the registers are wider than their legal range.
    task automatic random_settings;
        write_reg(REG_THR, CfgW'($urandom & 11'h7FF));
        write_reg(REG_SLOPE, CfgW'($urandom & 16'hFFFF));
        write_reg(REG_MIX, CfgW'(($urandom_range(0, 3) == 0) ? 17'd65536
                                                             : ($urandom & 17'h1FFFF)));
        write_reg(REG_ATT, CfgW'($urandom & 24'hFFFFFF));
        write_reg(REG_REL, CfgW'($urandom & 24'hFFFFFF));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_channel = 1'b0;
        i_main_sample = '0;
        i_side_sample = '0;
        quiet_sink = 1'b0;
        hold_sink = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes of both samples on both channels,
        // a zero envelope, and full-scale peaks that drive the gain down.
        send_beat(1'b0, 24'h000000, 24'h000000, 1'b0);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_beat(1'b1, 24'h800000, 24'h7FFFFF, 1'b0);
        send_beat(1'b1, 24'h000001, 24'hFFFFFF, 1'b0);
        drain();
        // Fastest attack and release, threshold at 0 dB and maximal slope.
        write_reg(REG_ATT, 24'd0);
        write_reg(REG_REL, 24'd0);
        write_reg(REG_THR, 24'd0);
        write_reg(REG_SLOPE, 24'hFFFF);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_beat(1'b0, 24'h800000, 24'h7FFFFF, 1'b0);
        send_beat(1'b1, 24'h400000, 24'h000001, 1'b0);
        drain();
        // Lowest threshold and a threshold below range; slowest coefficients.
        write_reg(REG_THR, 24'h400);
        write_reg(REG_ATT, 24'hFFFFFF);
        write_reg(REG_REL, 24'hFFFFFF);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_beat(1'b1, 24'h800000, 24'h000000, 1'b0);
        drain();
        write_reg(REG_THR, -24'sd960);
        // Mix zero bypasses and freezes the envelope; mix above full clamps.
        write_reg(REG_MIX, 24'd0);
        send_beat(1'b0, 24'h123456, 24'h800000, 1'b0);
        send_beat(1'b1, 24'h800000, 24'h7FFFFF, 1'b0);
        drain();
        write_reg(REG_MIX, 24'h1FFFF);
        write_reg(REG_ATT, 24'd0);
        write_reg(REG_THR, -24'sd960);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_beat(1'b0, 24'h800000, 24'h800000, 1'b0);
        drain();
        write_reg(REG_MIX, 24'd32768);
        send_beat(1'b1, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_beat(1'b1, 24'h800000, 24'h000010, 1'b0);
        drain();

        // Random phases with fresh settings; the second keeps the input full
        // while the receiver holds off.
        for (int ph = 0; ph < 10; ph++) begin
            random_settings();
            if (ph == 1) hold_sink = 1'b1;
            for (int i = 0; i < 200; i++) begin
                if (ph == 9 && i == 100) quiet_sink = 1'b1;
                send_beat(1'($urandom_range(0, 1)), pick_sample(), pick_sample(),
                    ph != 1 && ph != 9 || (ph == 9 && i < 100));
            end
            drain();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sidechain_compressor.f]
rtl/scc_pkg.sv
rtl/sidechain_compressor.sv
test/scc_checker.sv
test/testbench.sv
